// ----- sv/colmap_pkg.sv -----
// shared types and constants of the column occupancy map normalizer
package colmap_pkg;

   localparam int MaxSizeX   = 256;
   localparam int MaxSizeY   = 256;
   localparam int CountMax   = 2047;
   localparam int MapDepth   = MaxSizeX * MaxSizeY;
   localparam int AddrW      = $clog2(MapDepth);
   localparam int CountW     = $clog2(CountMax + 1);
   localparam int SizeW      = 9;
   localparam int CoordW     = 8;
   localparam int PixW       = 8;
   localparam int NumW       = CountW + PixW;
   localparam int QueueDepth = 2;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCntW      = $clog2(QueueDepth + 1);

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_FIN   = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      REG_SIZE_X = 1'b0,
      REG_SIZE_Y = 1'b1
   } reg_index_type;

   // effective sizes, already clamped to 1..max
   typedef struct packed {
      logic [SizeW-1:0] size_x;
      logic [SizeW-1:0] size_y;
   } cfg_type;

   typedef struct packed {
      op_type           op;
      logic [AddrW-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      logic    pop;
      cmd_type cmd;
   } q_if_type;

endpackage

// ----- sv/colmap_front.sv -----
// front end: checks coordinates, forms the linear index, filters no-op items
module colmap_front (
   input  logic                            clock,
   input  logic                            reset,
   input  colmap_pkg::cfg_type             cfg,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_type,
   input  logic [colmap_pkg::CoordW-1:0]   req_col_x,
   input  logic [colmap_pkg::CoordW-1:0]   req_col_y,
   input  logic                            req_occupied,
   input  logic                            q_full,
   output logic                            q_push,
   output colmap_pkg::cmd_type             q_cmd
);
   logic                              in_range;
   logic                              keep;
   logic [2*colmap_pkg::SizeW-1:0]    lin;
   colmap_pkg::op_type                op;

   assign op       = colmap_pkg::op_type'(req_type);
   assign req_ready = !q_full;
   assign in_range = ({1'b0, req_col_x} < cfg.size_x) && ({1'b0, req_col_y} < cfg.size_y);
   assign lin      = {{(colmap_pkg::SizeW+1){1'b0}}, req_col_x}
                   + ({{(colmap_pkg::SizeW+1){1'b0}}, req_col_y} * {9'd0, cfg.size_x});

   always_comb begin
      case (op)
         colmap_pkg::OP_CLEAR: keep = 1'b1;
         colmap_pkg::OP_FIN:   keep = 1'b1;
         colmap_pkg::OP_ADD:   keep = in_range && req_occupied;
         colmap_pkg::OP_READ:  keep = in_range;
         default:              keep = 1'b0;
      endcase
   end

   assign q_push    = req_valid && req_ready && keep;
   assign q_cmd.op  = op;
   assign q_cmd.idx = lin[colmap_pkg::AddrW-1:0];

   // clock and reset only feed the checks below
`ifndef ASSERT_OFF
   a_push_ready: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("push into full queue");
   a_drop_range: assert property (@(posedge clock) disable iff (reset)
      (req_valid && op == colmap_pkg::OP_READ && !in_range) |-> !q_push)
      else $error("out of range read queued");
   a_drop_empty: assert property (@(posedge clock) disable iff (reset)
      (req_valid && op == colmap_pkg::OP_ADD && !req_occupied) |-> !q_push)
      else $error("empty add queued");
`endif
endmodule

// ----- sv/colmap_queue.sv -----
// two-entry command queue between front and back
module colmap_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  colmap_pkg::cmd_type   push_cmd,
   output logic                  full,
   output colmap_pkg::q_if_type  q_out,
   input  logic                  pop
);
   colmap_pkg::cmd_type                   ent_ff [colmap_pkg::QueueDepth];
   logic [colmap_pkg::QPtrW-1:0]          wr_ff, wr_in, rd_ff, rd_in;
   logic [colmap_pkg::QCntW-1:0]          cnt_ff, cnt_in;

   assign full        = cnt_ff == colmap_pkg::QCntW'(colmap_pkg::QueueDepth);
   assign q_out.valid = cnt_ff != '0;
   assign q_out.pop   = pop;
   assign q_out.cmd   = ent_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + colmap_pkg::QCntW'(push) - colmap_pkg::QCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) ent_ff[wr_ff] <= push_cmd;
   end

`ifndef ASSERT_OFF
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_out.valid) else $error("pop from empty queue");
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= colmap_pkg::QCntW'(colmap_pkg::QueueDepth)) else $error("queue overflow");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("queue count slip");
`endif
endmodule

// ----- sv/colmap_back.sv -----
// back end: count map memory, clear sweep, min/max walk and pixel divider
module colmap_back (
   input  logic                           clock,
   input  logic                           reset,
   input  colmap_pkg::cfg_type            cfg,
   input  colmap_pkg::q_if_type           q_in,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [colmap_pkg::PixW-1:0]    rsp_pixel_value,
   output logic [colmap_pkg::AddrW-1:0]   rsp_pixel_index
);
   localparam int AW = colmap_pkg::AddrW;
   localparam int CW = colmap_pkg::CountW;
   localparam int NW = colmap_pkg::NumW;

   typedef enum logic [8:0] {
      S_CLEAR   = 9'b000000001,
      S_IDLE    = 9'b000000010,
      S_ADD_RD  = 9'b000000100,
      S_ADD_WR  = 9'b000001000,
      S_FIN     = 9'b000010000,
      S_FIN_END = 9'b000100000,
      S_RD      = 9'b001000000,
      S_RD_DAT  = 9'b010000000,
      S_DIV     = 9'b100000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             mem [colmap_pkg::MapDepth];
   logic [CW-1:0]             rd_data_ff;
   logic [AW-1:0]             mem_ra, mem_wa;
   logic [CW-1:0]             mem_wd;
   logic                      mem_we;
   logic [AW-1:0]             idx_ff, idx_in;
   logic [AW:0]               cnt_ff, cnt_in;
   logic [AW:0]               total;
   logic                      first_ff, first_in;
   logic                      pend_ff;
   logic [CW-1:0]             lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0]             rmin_ff, rmin_in, rmax_ff, rmax_in;
   logic [NW-1:0]             rem_ff, rem_in, trial;
   logic [CW-1:0]             den_ff, den_in, clamped;
   logic [colmap_pkg::PixW-1:0] q_ff, q_in_v;
   logic [2:0]                bit_ff, bit_in;
   logic                      out_v_ff, out_v_in, done, out_free;
   logic [colmap_pkg::PixW-1:0] out_pix_ff;
   logic [AW-1:0]             out_idx_ff;
   logic                      take;

   assign total    = (AW+1)'({9'd0, cfg.size_x} * {9'd0, cfg.size_y});
   assign mem_ra   = (state_ff == S_FIN) ? cnt_ff[AW-1:0] : idx_ff;
   assign out_free = !out_v_ff || rsp_ready;
   assign q_pop    = (state_ff == S_IDLE) && q_in.valid;
   assign trial    = NW'({{(NW-CW){1'b0}}, den_ff} << bit_ff);
   assign clamped  = (rd_data_ff < rmin_ff) ? rmin_ff :
                     (rd_data_ff > rmax_ff) ? rmax_ff : rd_data_ff;
   assign done     = (state_ff == S_DIV) && (bit_ff == 3'd0) && out_free;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      first_in = first_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      rmin_in  = rmin_ff;
      rmax_in  = rmax_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      q_in_v   = q_ff;
      bit_in   = bit_ff;
      mem_we   = 1'b0;
      mem_wa   = idx_ff;
      mem_wd   = '0;
      take     = 1'b0;
      // fold the word read in the previous cycle during the walk
      if (pend_ff) begin
         first_in = 1'b0;
         lo_in    = (first_ff || rd_data_ff < lo_ff) ? rd_data_ff : lo_ff;
         hi_in    = (first_ff || rd_data_ff > hi_ff) ? rd_data_ff : hi_ff;
      end
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = cnt_ff[AW-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[AW-1:0] == {AW{1'b1}}) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (q_in.valid) begin
               idx_in = q_in.cmd.idx;
               cnt_in = '0;
               case (q_in.cmd.op)
                  colmap_pkg::OP_CLEAR: begin
                     rmin_in  = '0;
                     rmax_in  = '0;
                     state_in = S_CLEAR;
                  end
                  colmap_pkg::OP_ADD: state_in = S_ADD_RD;
                  colmap_pkg::OP_FIN: begin
                     first_in = 1'b1;
                     state_in = S_FIN;
                  end
                  colmap_pkg::OP_READ: state_in = S_RD;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ADD_RD: state_in = S_ADD_WR;
         S_ADD_WR: begin
            mem_we   = rd_data_ff != CW'(colmap_pkg::CountMax);
            mem_wd   = rd_data_ff + 1'b1;
            state_in = S_IDLE;
         end
         S_FIN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == total - 1'b1) state_in = S_FIN_END;
         end
         S_FIN_END: begin
            rmin_in  = lo_in;
            rmax_in  = hi_in;
            state_in = S_IDLE;
         end
         S_RD: state_in = S_RD_DAT;
         S_RD_DAT: begin
            rem_in   = NW'({{(NW-CW){1'b0}}, clamped - rmin_ff}) * NW'(255);
            den_in   = rmax_ff - rmin_ff;
            q_in_v   = '0;
            bit_in   = 3'd7;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (den_ff != '0 && rem_ff >= trial && !(bit_ff == 3'd0 && !out_free && q_ff[0])) begin
               if (!q_ff[bit_ff]) begin
                  rem_in        = rem_ff - trial;
                  q_in_v[bit_ff] = 1'b1;
               end
            end
            if (bit_ff != 3'd0) begin
               bit_in = bit_ff - 1'b1;
            end else if (out_free) begin
               take     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      out_v_in = take ? 1'b1 : (rsp_ready ? 1'b0 : out_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         rmin_ff  <= '0;
         rmax_ff  <= '0;
         pend_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rmin_ff  <= rmin_in;
         rmax_ff  <= rmax_in;
         pend_ff  <= state_ff == S_FIN;
         out_v_ff <= out_v_in;
      end
      idx_ff   <= idx_in;
      first_ff <= first_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      q_ff     <= q_in_v;
      bit_ff   <= bit_in;
      if (take) begin
         out_pix_ff <= q_in_v;
         out_idx_ff <= idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_data_ff <= mem[mem_ra];
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_pixel_value = out_pix_ff;
   assign rsp_pixel_index = out_idx_ff;

`ifndef ASSERT_OFF
   a_range_order: assert property (@(posedge clock) disable iff (reset)
      rmin_ff <= rmax_ff) else $error("range minimum above maximum");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == S_IDLE) else $error("pop outside idle");
   a_take_free: assert property (@(posedge clock) disable iff (reset)
      take |-> out_free) else $error("result overwritten");
   a_done_take: assert property (@(posedge clock) disable iff (reset)
      done |-> take) else $error("divider finish lost");
`endif
endmodule

// ----- sv/column_occupancy_map_normalizer_unit.sv -----
// column occupancy map normalizer: top level with config registers
// add: in the back end, dispatch, memory read, then saturating write back
// read: from queue to result, dispatch, read, clamp and scale, then 8 divider steps
// finalize: one map word a cycle on the memory read port, over size_x*size_y words
// clear: dispatch then one word a cycle over the whole map; reset starts a full clearing pass
// front accepts items into a two-entry queue while the back end works, until the queue is full
module column_occupancy_map_normalizer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_col_x,
   input  logic [7:0]  req_col_y,
   input  logic        req_occupied,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pixel_value,
   output logic [15:0] rsp_pixel_index,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   // raw size registers as written
   logic [colmap_pkg::SizeW-1:0] size_x_ff, size_x_in, size_y_ff, size_y_in;
   colmap_pkg::cfg_type          cfg;
   colmap_pkg::q_if_type         q_if;
   colmap_pkg::cmd_type          push_cmd;
   colmap_pkg::reg_index_type    sel;
   logic                         wr_en, q_full, q_push, q_pop;

   assign pready = 1'b1;
   assign sel    = colmap_pkg::reg_index_type'(paddr[2]);
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      if (wr_en) begin
         case (sel)
            colmap_pkg::REG_SIZE_X: size_x_in = pwdata[colmap_pkg::SizeW-1:0];
            colmap_pkg::REG_SIZE_Y: size_y_in = pwdata[colmap_pkg::SizeW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (sel)
         colmap_pkg::REG_SIZE_X: prdata = {23'd0, size_x_ff};
         colmap_pkg::REG_SIZE_Y: prdata = {23'd0, size_y_ff};
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= colmap_pkg::SizeW'(colmap_pkg::MaxSizeX);
         size_y_ff <= colmap_pkg::SizeW'(colmap_pkg::MaxSizeY);
      end else begin
         size_x_ff <= size_x_in;
         size_y_ff <= size_y_in;
      end
   end

   // zero acts as one, anything past the map edge acts as the edge
   assign cfg.size_x = (size_x_ff == '0) ? colmap_pkg::SizeW'(1) :
      (size_x_ff > colmap_pkg::SizeW'(colmap_pkg::MaxSizeX)) ?
      colmap_pkg::SizeW'(colmap_pkg::MaxSizeX) : size_x_ff;
   assign cfg.size_y = (size_y_ff == '0) ? colmap_pkg::SizeW'(1) :
      (size_y_ff > colmap_pkg::SizeW'(colmap_pkg::MaxSizeY)) ?
      colmap_pkg::SizeW'(colmap_pkg::MaxSizeY) : size_y_ff;

   // classify each transfer and drop the ones with no effect
   colmap_front u_front (
      .clock, .reset, .cfg,
      .req_valid, .req_ready, .req_type, .req_col_x, .req_col_y, .req_occupied,
      .q_full, .q_push, .q_cmd(push_cmd)
   );

   colmap_queue u_queue (
      .clock, .reset, .push(q_push), .push_cmd, .full(q_full),
      .q_out(q_if), .pop(q_pop)
   );

   // map memory and the per-command sequencer
   colmap_back u_back (
      .clock, .reset, .cfg, .q_in(q_if), .q_pop,
      .rsp_valid, .rsp_ready, .rsp_pixel_value, .rsp_pixel_index
   );
endmodule

// ----- verif/column_occupancy_map_normalizer_unit_checker.sv -----
// checker for the column map normalizer: predicts pixel transfers and compares them
`timescale 1ns / 100ps
module column_occupancy_map_normalizer_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_col_x,
   input  logic [7:0]  req_col_y,
   input  logic        req_occupied,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_pixel_value,
   input  logic [15:0] rsp_pixel_index,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          errors,
   output int          pending
);

   typedef struct packed {
      logic [7:0]  value;
      logic [15:0] index;
   } pixel_type;

   logic [colmap_pkg::CountW-1:0] col_count [0:colmap_pkg::MapDepth-1];
   logic [colmap_pkg::CountW-1:0] lo_count;
   logic [colmap_pkg::CountW-1:0] hi_count;
   logic [colmap_pkg::SizeW-1:0]  size_x_reg;
   logic [colmap_pkg::SizeW-1:0]  size_y_reg;
   pixel_type                     pixel_queue [$];

   function automatic int eff_size(logic [colmap_pkg::SizeW-1:0] v, int maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : int'(v);
   endfunction

   function automatic void wipe_map();
      for (int i = 0; i < colmap_pkg::MapDepth; i++) col_count[i] = '0;
      lo_count = '0;
      hi_count = '0;
   endfunction

   task automatic predict_pixel(colmap_pkg::op_type op, int x, int y, logic occ);
      int        sx;
      int        sy;
      int        idx;
      int        c;
      int        lo;
      int        hi;
      pixel_type px;
      sx = eff_size(size_x_reg, colmap_pkg::MaxSizeX);
      sy = eff_size(size_y_reg, colmap_pkg::MaxSizeY);
      case (op)
         colmap_pkg::OP_CLEAR: wipe_map();
         colmap_pkg::OP_FIN: begin
            lo = col_count[0];
            hi = col_count[0];
            for (int i = 1; i < sx * sy; i++) begin
               if (col_count[i] < lo) lo = col_count[i];
               if (col_count[i] > hi) hi = col_count[i];
            end
            lo_count = lo[colmap_pkg::CountW-1:0];
            hi_count = hi[colmap_pkg::CountW-1:0];
         end
         default: begin
            if (x < sx && y < sy) begin
               idx = x + y * sx;
               if (op == colmap_pkg::OP_ADD) begin
                  if (occ && col_count[idx] < colmap_pkg::CountMax)
                     col_count[idx] = col_count[idx] + 1'b1;
               end else begin
                  c  = col_count[idx];
                  lo = lo_count;
                  hi = hi_count;
                  px.value = '0;
                  if (hi > lo) begin
                     // counts outside the latched range clamp to its ends
                     if (c < lo) c = lo;
                     if (c > hi) c = hi;
                     px.value = 8'((255 * (c - lo)) / (hi - lo));
                  end
                  px.index = 16'(idx);
                  pixel_queue.push_back(px);
               end
            end
         end
      endcase
   endtask

   initial begin
      wipe_map();
      size_x_reg = 9'd256;
      size_y_reg = 9'd256;
      errors     = 0;
   end

   assign pending = pixel_queue.size();

   always @(posedge clock) begin
      pixel_type exp_px;
      if (!reset) begin
         if (psel && penable && pwrite && pready) begin
            if (colmap_pkg::reg_index_type'(paddr[2]) == colmap_pkg::REG_SIZE_Y)
               size_y_reg = pwdata[colmap_pkg::SizeW-1:0];
            else size_x_reg = pwdata[colmap_pkg::SizeW-1:0];
         end
         if (req_valid && req_ready)
            predict_pixel(colmap_pkg::op_type'(req_type), req_col_x, req_col_y,
                          req_occupied);
         if (rsp_valid && rsp_ready) begin
            if (pixel_queue.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected pixel transfer value=%0d index=%0d",
                           rsp_pixel_value, rsp_pixel_index);
            end else begin
               exp_px = pixel_queue.pop_front();
               if (rsp_pixel_value !== exp_px.value || rsp_pixel_index !== exp_px.index) begin
                  errors++;
                  if (errors <= 10)
                     $display("pixel mismatch: expected value=%0d index=%0d, got value=%0d index=%0d",
                              exp_px.value, exp_px.index, rsp_pixel_value, rsp_pixel_index);
               end
            end
         end
      end
   end

endmodule

// ----- verif/column_occupancy_map_normalizer_unit_tb.sv -----
// testbench top for the column map normalizer: stimulus, flow control and verdict
`timescale 1ns / 100ps
module column_occupancy_map_normalizer_unit_tb;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type     = colmap_pkg::OP_CLEAR;
   logic [7:0]  req_col_x    = '0;
   logic [7:0]  req_col_y    = '0;
   logic        req_occupied = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready    = 1'b0;
   logic [7:0]  rsp_pixel_value;
   logic [15:0] rsp_pixel_index;
   logic        psel         = 1'b0;
   logic        penable      = 1'b0;
   logic        pwrite       = 1'b0;
   logic [2:0]  paddr        = '0;
   logic [31:0] pwdata       = '0;
   logic [31:0] prdata;
   logic        pready;
   int          errors;
   int          pending;

   // sender burst bookkeeping
   int          burst_left   = 0;
   // effective sizes as the block sees them, for choosing coordinates
   int          cur_sx       = 256;
   int          cur_sy       = 256;
   int          clears_left  = 2;
   // long receiver hold, requested by bumping hold_req
   int          hold_req     = 0;
   int          hold_seen    = 0;
   int          hold_left    = 0;
   logic [9:0]  stall_phase  = '0;

   always #5 clock = ~clock;

   column_occupancy_map_normalizer_unit u_dut (.*);

   column_occupancy_map_normalizer_unit_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_type, .req_col_x, .req_col_y,
      .req_occupied, .rsp_valid, .rsp_ready, .rsp_pixel_value, .rsp_pixel_index,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .errors, .pending
   );

   // receiver: a long hold on request, else stall modes that rotate in turn
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         stall_phase <= stall_phase + 1'b1;
         case (stall_phase[8:7])
            2'd0:    rsp_ready <= 1'b1;
            2'd1:    rsp_ready <= ($urandom_range(0, 1) == 0);
            2'd2:    rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (stall_phase[3:0] != 4'd0);
         endcase
      end
   end

   // one item per call, called at a rising edge; leaves valid high at the accepting edge
   task automatic send_item(colmap_pkg::op_type op, int x, int y, logic occ);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_type     <= op;
      req_col_x    <= 8'(x);
      req_col_y    <= 8'(y);
      req_occupied <= occ;
      req_valid    <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // drain: a read at the origin always answers, so once it comes back all work is done
   task automatic drain();
      send_item(colmap_pkg::OP_READ, 0, 0, 1'b0);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(colmap_pkg::reg_index_type r, logic [8:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {r, 2'b00};
      pwdata  <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (r == colmap_pkg::REG_SIZE_X)
         cur_sx = value == 0 ? 1 : (value > colmap_pkg::MaxSizeX ? colmap_pkg::MaxSizeX : value);
      else
         cur_sy = value == 0 ? 1 : (value > colmap_pkg::MaxSizeY ? colmap_pkg::MaxSizeY : value);
   endtask

   task automatic set_sizes(logic [8:0] sx, logic [8:0] sy);
      csr_write(colmap_pkg::REG_SIZE_X, sx);
      csr_write(colmap_pkg::REG_SIZE_Y, sy);
   endtask

   // random phase: mostly in-range adds and reads, some finalizes, rare clears and out-of-range noise
   task automatic random_phase(int n_items, bit read_heavy);
      int  pick;
      int  x;
      int  y;
      bit  big;
      big = (cur_sx * cur_sy > 4096);
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 9) == 0) begin
            x = $urandom_range(0, 255);
            y = $urandom_range(0, 255);
         end else begin
            x = $urandom_range(0, cur_sx - 1);
            y = $urandom_range(0, cur_sy - 1);
         end
         // walking a big map is slow, so it gets exactly one finalize
         if (big && i == n_items / 2)
            send_item(colmap_pkg::OP_FIN, x, y, 1'b0);
         else if (clears_left > 0 && pick == 0) begin
            clears_left--;
            send_item(colmap_pkg::OP_CLEAR, x, y, 1'b1);
         end else if (!big && pick < 11)
            send_item(colmap_pkg::OP_FIN, x, y, 1'($urandom_range(0, 1)));
         else if (pick < (read_heavy ? 30 : 55))
            send_item(colmap_pkg::OP_ADD, x, y, $urandom_range(0, 7) != 0);
         else
            send_item(colmap_pkg::OP_READ, x, y, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // let the clearing pass after reset finish
      repeat (66000) @(posedge clock);

      // directed: small map, flat range, extremes, occupied clear, out-of-range
      set_sizes(9'd4, 9'd3);
      send_item(colmap_pkg::OP_READ, 0, 0, 1'b0);
      send_item(colmap_pkg::OP_ADD, 3, 2, 1'b1);
      send_item(colmap_pkg::OP_ADD, 3, 2, 1'b1);
      send_item(colmap_pkg::OP_ADD, 3, 2, 1'b1);
      send_item(colmap_pkg::OP_ADD, 0, 0, 1'b1);
      send_item(colmap_pkg::OP_ADD, 1, 1, 1'b0);
      send_item(colmap_pkg::OP_ADD, 4, 0, 1'b1);
      send_item(colmap_pkg::OP_ADD, 255, 255, 1'b1);
      send_item(colmap_pkg::OP_FIN, 0, 0, 1'b0);
      send_item(colmap_pkg::OP_READ, 3, 2, 1'b0);
      send_item(colmap_pkg::OP_READ, 0, 0, 1'b1);
      send_item(colmap_pkg::OP_READ, 1, 1, 1'b0);
      send_item(colmap_pkg::OP_READ, 4, 0, 1'b0);
      send_item(colmap_pkg::OP_READ, 0, 3, 1'b0);
      send_item(colmap_pkg::OP_ADD, 3, 2, 1'b1);
      send_item(colmap_pkg::OP_READ, 3, 2, 1'b0);
      send_item(colmap_pkg::OP_CLEAR, 0, 0, 1'b0);
      send_item(colmap_pkg::OP_READ, 3, 2, 1'b0);
      drain();

      // size zero acts as one; then count below range after widening the map
      set_sizes(9'd0, 9'd0);
      send_item(colmap_pkg::OP_ADD, 0, 0, 1'b1);
      send_item(colmap_pkg::OP_ADD, 1, 0, 1'b1);
      drain();
      set_sizes(9'd2, 9'd1);
      send_item(colmap_pkg::OP_ADD, 0, 0, 1'b1);
      send_item(colmap_pkg::OP_ADD, 1, 0, 1'b1);
      send_item(colmap_pkg::OP_ADD, 1, 0, 1'b1);
      send_item(colmap_pkg::OP_FIN, 0, 0, 1'b0);
      drain();
      set_sizes(9'd3, 9'd1);
      send_item(colmap_pkg::OP_READ, 2, 0, 1'b0);
      send_item(colmap_pkg::OP_READ, 1, 0, 1'b0);
      drain();

      // random phases over several settings, extremes included
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0:       set_sizes(9'd511, 9'd256);
            1:       set_sizes(9'd256, 9'd1);
            2:       set_sizes(9'd1, 9'd256);
            3:       set_sizes(9'd0, 9'd5);
            default: set_sizes(9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)));
         endcase
         if (ph == 5) hold_req++;
         random_phase(55, ph == 5);
         // sender waits for every pending result before the next setting
         drain();
      end
      set_sizes(9'd256, 9'd256);
      send_item(colmap_pkg::OP_READ, 255, 255, 1'b1);
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #50ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
